### sv/dcnc_pkg.sv
// shared types, constants and helpers of the character/number conversion unit
`default_nettype none

package dcnc_pkg;

  // pipeline depth, the last stage is the output register
  localparam int unsigned NumStages = 4;

  // word layout
  localparam int unsigned WordW    = 30;
  localparam int unsigned ByteW    = 6;
  localparam int unsigned NumBytes = 5;
  localparam int unsigned DigitW   = 4;
  localparam int unsigned NumDigits = 2 * NumBytes;

  // a group of five decimal digits stays below 100000
  localparam int unsigned GroupW = 17;
  // ten decimal digits stay below 2^34
  localparam int unsigned NumW   = 34;

  // stream payload widths
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 64;

  localparam logic [GroupW-1:0] GroupBase = 17'd100000;
  localparam logic [ByteW-1:0]  CharBase  = 6'd30;
  localparam logic [ByteW-1:0]  CharTop   = 6'd39;

  // reciprocal for splitting a word into two five-digit groups
  localparam int unsigned SplitShift = 47;
  localparam logic [30:0] SplitMul =
    31'(((64'd1 << SplitShift) + 64'd99999) / 64'd100000);

  // reciprocals for taking a five-digit group apart
  localparam int unsigned DigShift = 34;
  localparam logic [30:0] Div10Mul    = 31'(((64'd1 << DigShift) + 64'd9) / 64'd10);
  localparam logic [30:0] Div100Mul   = 31'(((64'd1 << DigShift) + 64'd99) / 64'd100);
  localparam logic [30:0] Div1000Mul  = 31'(((64'd1 << DigShift) + 64'd999) / 64'd1000);
  localparam logic [30:0] Div10000Mul = 31'(((64'd1 << DigShift) + 64'd9999) / 64'd10000);

  typedef enum logic {
    OP_NUM  = 1'b0,
    OP_CHAR = 1'b1
  } op_e;

  // per-stage load enables and valid bits
  typedef struct packed {
    logic [NumStages-1:0] en;
    logic [NumStages-1:0] vld;
  } pipe_ctl_t;

  // byte value modulo 10, byte below 64
  function automatic logic [DigitW-1:0] mod10(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    r = b;
    if (r >= 6'd40) r = r - 6'd40;
    if (r >= 6'd20) r = r - 6'd20;
    if (r >= 6'd10) r = r - 6'd10;
    return r[DigitW-1:0];
  endfunction

  // reciprocal of 10^k for a digit position, zero for position 0
  function automatic logic [30:0] div_mul(input logic [2:0] k);
    logic [30:0] m;
    case (k)
      3'd1:    m = Div10Mul;
      3'd2:    m = Div100Mul;
      3'd3:    m = Div1000Mul;
      3'd4:    m = Div10000Mul;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

### sv/dcnc_pipe_ctrl.sv
// valid bits and stall-aware load enables of the conversion pipeline
`default_nettype none

module dcnc_pipe_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              out_ready_i,
  output dcnc_pkg::pipe_ctl_t    ctl_o
);
  import dcnc_pkg::*;

  logic [NumStages-1:0] vld_q, vld_d;
  logic [NumStages-1:0] en;

  // a stage loads when it is empty or its successor moves on
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  // valid bits follow the data
  always_comb begin
    vld_d = vld_q;
    if (en[0]) vld_d[0] = in_valid_i;
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctl_o.en  = en;
  assign ctl_o.vld = vld_q;

endmodule

`default_nettype wire

### sv/dcnc_num_path.sv
// digits-to-number datapath: byte digits, five-digit groups, full number, wrap
`default_nettype none

module dcnc_num_path (
  input  wire logic                        clk_i,
  input  wire dcnc_pkg::pipe_ctl_t         ctl_i,
  input  wire logic [dcnc_pkg::WordW-1:0]  acc_word_i,
  input  wire logic [dcnc_pkg::WordW-1:0]  ext_word_i,
  output logic      [dcnc_pkg::WordW-1:0]  acc_word_o,
  output logic                             overflow_o
);
  import dcnc_pkg::*;

  logic [2*WordW-1:0]  all_bytes;
  logic [DigitW-1:0]   dig_q [NumDigits];
  logic [GroupW-1:0]   grp_d [2];
  logic [GroupW-1:0]   grp_q [2];
  logic [NumW-1:0]     num_q;
  logic [WordW-1:0]    acc_q;
  logic                ovf_q;

  // accumulator bytes first, most significant first
  assign all_bytes = {acc_word_i, ext_word_i};

  // stage 0: each byte modulo 10
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      for (int i = 0; i < NumDigits; i++) begin
        dig_q[i] <= mod10(all_bytes[2*WordW-1-ByteW*i -: ByteW]);
      end
    end
  end

  // stage 1: five digits to a group value
  always_comb begin
    for (int g = 0; g < 2; g++) begin
      grp_d[g] = GroupW'(dig_q[5*g])   * 17'd10000
               + GroupW'(dig_q[5*g+1]) * 17'd1000
               + GroupW'(dig_q[5*g+2]) * 17'd100
               + GroupW'(dig_q[5*g+3]) * 17'd10
               + GroupW'(dig_q[5*g+4]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1]) begin
      grp_q[0] <= grp_d[0];
      grp_q[1] <= grp_d[1];
    end
  end

  // stage 2: high group times 100000 plus low group
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[2]) begin
      num_q <= NumW'(grp_q[0]) * NumW'(GroupBase) + NumW'(grp_q[1]);
    end
  end

  // stage 3: wrap to the word and flag overflow
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[3]) begin
      acc_q <= num_q[WordW-1:0];
      ovf_q <= |num_q[NumW-1:WordW];
    end
  end

  assign acc_word_o = acc_q;
  assign overflow_o = ovf_q;

endmodule

`default_nettype wire

### sv/dcnc_char_path.sv
// number-to-characters datapath: split by 100000, digit quotients, codes
`default_nettype none

module dcnc_char_path (
  input  wire logic                        clk_i,
  input  wire dcnc_pkg::pipe_ctl_t         ctl_i,
  input  wire logic [dcnc_pkg::WordW-1:0]  acc_word_i,
  output logic      [dcnc_pkg::WordW-1:0]  acc_word_o,
  output logic      [dcnc_pkg::WordW-1:0]  ext_word_o
);
  import dcnc_pkg::*;

  localparam int unsigned ProdW = WordW + 31;
  localparam int unsigned QuotW = 14;

  logic [ProdW-1:0]   prod_q;
  logic [WordW-1:0]   acc0_q;
  logic [QuotW-1:0]   hi_quot;
  logic [30:0]        hi_scaled;
  logic [WordW-1:0]   lo_full;
  logic [GroupW-1:0]  grp_q  [2];
  logic [47:0]        dprod  [2][NumBytes];
  logic [GroupW-1:0]  quot_q [2][NumBytes];
  logic [GroupW-1:0]  dig_full [2][NumBytes];
  logic [WordW-1:0]   word_d [2];
  logic [WordW-1:0]   acc_q, ext_q;

  // stage 0: reciprocal multiply for the split by 100000
  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      prod_q <= ProdW'(acc_word_i) * ProdW'(SplitMul);
      acc0_q <= acc_word_i;
    end
  end

  // stage 1: high group and remainder
  assign hi_quot   = prod_q[SplitShift +: QuotW];
  assign hi_scaled = 31'(hi_quot) * 31'(GroupBase);
  assign lo_full   = acc0_q - hi_scaled[WordW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1]) begin
      grp_q[0] <= GroupW'(hi_quot);
      grp_q[1] <= lo_full[GroupW-1:0];
    end
  end

  // stage 2: quotients of each group by 10^k
  always_comb begin
    for (int g = 0; g < 2; g++) begin
      for (int k = 0; k < NumBytes; k++) begin
        dprod[g][k] = 48'(grp_q[g]) * 48'(div_mul(3'(k)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[2]) begin
      for (int g = 0; g < 2; g++) begin
        quot_q[g][0] <= grp_q[g];
        for (int k = 1; k < NumBytes; k++) begin
          quot_q[g][k] <= GroupW'(dprod[g][k][47:DigShift]);
        end
      end
    end
  end

  // stage 3: digit = quotient minus ten times the next quotient, then code
  always_comb begin
    for (int g = 0; g < 2; g++) begin
      word_d[g] = '0;
      for (int k = 0; k < NumBytes; k++) begin
        if (k == NumBytes - 1) begin
          dig_full[g][k] = quot_q[g][k];
        end else begin
          dig_full[g][k] = quot_q[g][k] - (quot_q[g][k+1] << 3) - (quot_q[g][k+1] << 1);
        end
        word_d[g][ByteW*k +: ByteW] = CharBase + ByteW'(dig_full[g][k][DigitW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[3]) begin
      acc_q <= word_d[0];
      ext_q <= word_d[1];
    end
  end

  assign acc_word_o = acc_q;
  assign ext_word_o = ext_q;

endmodule

`default_nettype wire

### sv/decimal_char_numeric_convert_unit.sv
// top level of the character/number conversion unit
//
//   channel  dir  handshake                        payload
//   s_axis   in   s_axis_tvalid / s_axis_tready    tdata: sign, acc, ext; tuser: operation
//   m_axis   out  m_axis_tvalid / m_axis_tready    tdata: sign, acc, ext, overflow
//
// four register stages, one item per cycle sustained while m_axis is not stalled
// the depth is set by the reciprocal multiplies of the split by 100000 and
// of the per-digit quotients, each followed by a register
// reset clears only the stage valid bits, the pipeline comes up empty
// a stall on m_axis holds the last full stage; empty stages ahead of it
// keep taking items until the pipeline is full
`default_nettype none

module decimal_char_numeric_convert_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // acc_sign [0], acc_word [30:1], ext_word [60:31], zero fill [63:61]
  input  wire logic [dcnc_pkg::InDataW-1:0]   s_axis_tdata,
  // operation [0]
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // acc_sign_out [0], acc_word_out [30:1], ext_word_out [60:31],
  // overflow_set [61], zero fill [63:62]
  output logic      [dcnc_pkg::OutDataW-1:0]  m_axis_tdata
);
  import dcnc_pkg::*;

  pipe_ctl_t          ctl;
  logic [WordW-1:0]   in_acc, in_ext;
  op_e                op_q   [NumStages];
  logic               sign_q [NumStages];
  logic [WordW-1:0]   ext_q  [NumStages];
  logic [WordW-1:0]   num_acc, chr_acc, chr_ext;
  logic               num_ovf;
  logic [WordW-1:0]   out_acc, out_ext;
  logic               out_ovf;

  assign in_acc = s_axis_tdata[WordW:1];
  assign in_ext = s_axis_tdata[2*WordW:WordW+1];

  // pipeline control
  dcnc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctl_o       (ctl)
  );

  assign s_axis_tready = ctl.en[0];
  assign m_axis_tvalid = ctl.vld[NumStages-1];

  // operation, sign and extension ride along with the item
  always_ff @(posedge clk_i) begin
    if (ctl.en[0]) begin
      op_q[0]   <= op_e'(s_axis_tuser);
      sign_q[0] <= s_axis_tdata[0];
      ext_q[0]  <= in_ext;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (ctl.en[k]) begin
        op_q[k]   <= op_q[k-1];
        sign_q[k] <= sign_q[k-1];
        ext_q[k]  <= ext_q[k-1];
      end
    end
  end

  dcnc_num_path u_num (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .acc_word_i (in_acc),
    .ext_word_i (in_ext),
    .acc_word_o (num_acc),
    .overflow_o (num_ovf)
  );

  dcnc_char_path u_char (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .acc_word_i (in_acc),
    .acc_word_o (chr_acc),
    .ext_word_o (chr_ext)
  );

  // result select by operation
  always_comb begin
    case (op_q[NumStages-1])
      OP_CHAR: begin
        out_acc = chr_acc;
        out_ext = chr_ext;
        out_ovf = 1'b0;
      end
      default: begin
        out_acc = num_acc;
        out_ext = ext_q[NumStages-1];
        out_ovf = num_ovf;
      end
    endcase
  end

  assign m_axis_tdata = {2'b00, out_ovf, out_ext, out_acc, sign_q[NumStages-1]};

`ifndef SYNTHESIS
  // overflow is a NUM result only
  a_no_ovf_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (op_q[NumStages-1] == OP_CHAR) |-> !m_axis_tdata[2*WordW+1])
    else $error("overflow flag set on a CHAR item");

  // an empty output stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctl.vld[NumStages-1] |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // the lowest character code of acc and of ext stays within the digit range
  a_char_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (op_q[NumStages-1] == OP_CHAR) |->
      (m_axis_tdata[WordW+ByteW:WordW+1] >= CharBase) &&
      (m_axis_tdata[WordW+ByteW:WordW+1] <= CharTop) &&
      (m_axis_tdata[ByteW:1] >= CharBase) && (m_axis_tdata[ByteW:1] <= CharTop))
    else $error("character code out of range");

  // a stalled item stays in the output stage
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed under stall");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
// self-checking stream testbench for the character/number conversion unit
`timescale 1ns / 100ps

module testbench;
  import dcnc_pkg::*;

  typedef struct packed {
    logic             sign;
    logic [WordW-1:0] acc;
    logic [WordW-1:0] ext;
    logic             ovf;
  } conv_result_t;

  localparam longint unsigned WordLimit = 64'd1 << WordW;
  localparam logic [WordW-1:0] WordMax  = {WordW{1'b1}};

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // acc_sign [0], acc_word [30:1], ext_word [60:31], zero fill [63:61]
  logic [InDataW-1:0]  s_axis_tdata;
  // operation [0]
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // acc_sign_out [0], acc_word_out [30:1], ext_word_out [60:31],
  // overflow_set [61], zero fill [63:62]
  logic [OutDataW-1:0] m_axis_tdata;

  conv_result_t pending_results[$];
  int           err_count;
  int           src_idle_pct;
  int           sink_stall_pct;
  conv_result_t got_res;
  conv_result_t want_res;

  decimal_char_numeric_convert_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // expected conversion of one item
  function automatic conv_result_t convert_word(input op_e op, input logic sign,
                                                input logic [WordW-1:0] acc,
                                                input logic [WordW-1:0] ext);
    conv_result_t     res;
    longint unsigned  num;
    logic [2*WordW-1:0] both;
    res      = '0;
    res.sign = sign;
    if (op == OP_NUM) begin
      // acc bytes are the high digits, each byte taken modulo 10
      both = {acc, ext};
      num  = 0;
      for (int i = NumDigits - 1; i >= 0; i--) begin
        num = num * 10 + (both[i*ByteW +: ByteW] % 10);
      end
      res.ovf = (num >= WordLimit);
      res.acc = num[WordW-1:0];
      res.ext = ext;
    end else begin
      // low five digits go to ext, high five to acc
      num = acc;
      for (int i = 0; i < NumDigits; i++) begin
        if (i < NumBytes) begin
          res.ext[i*ByteW +: ByteW] = CharBase + ByteW'(num % 10);
        end else begin
          res.acc[(i-NumBytes)*ByteW +: ByteW] = CharBase + ByteW'(num % 10);
        end
        num = num / 10;
      end
    end
    return res;
  endfunction

  // spread a decimal number over acc and ext bytes, optionally with bytes above 9
  function automatic logic [2*WordW-1:0] digits_to_bytes(input longint unsigned n,
                                                         input bit scramble);
    logic [2*WordW-1:0] words;
    int                 digit;
    words = '0;
    for (int i = 0; i < NumDigits; i++) begin
      digit = int'(n % 10);
      n     = n / 10;
      if (scramble) digit += 10 * $urandom_range((63 - digit) / 10);
      words[i*ByteW +: ByteW] = ByteW'(digit);
    end
    return words;
  endfunction

  task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    err_count++;
  endtask

  // send one item, idling a random number of cycles before it
  task automatic send_item(input op_e op, input logic sign,
                           input logic [WordW-1:0] acc, input logic [WordW-1:0] ext);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, ext, acc, sign};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    pending_results.push_back(convert_word(op, sign, acc, ext));
    @(negedge clk_i);
  endtask

  task automatic send_number(input logic sign, input longint unsigned n, input bit scramble);
    logic [2*WordW-1:0] words;
    words = digits_to_bytes(n, scramble);
    send_item(OP_NUM, sign, words[2*WordW-1:WordW], words[WordW-1:0]);
  endtask

  // digits to number: zero, limits, overflow edge, bytes above 9
  task automatic test_num_directed();
    send_item(OP_NUM, 1'b0, '0, '0);
    send_item(OP_NUM, 1'b1, '0, '0);
    send_item(OP_NUM, 1'b0, WordMax, WordMax);
    send_number(1'b0, WordLimit - 1, 1'b0);
    send_number(1'b1, WordLimit, 1'b0);
    send_number(1'b0, 64'd9999999999, 1'b0);
    send_number(1'b1, WordLimit - 1, 1'b1);
    send_number(1'b0, WordLimit + 1, 1'b1);
    send_item(OP_NUM, 1'b0, {6'd63, 6'd10, 6'd19, 6'd45, 6'd58},
              {6'd20, 6'd31, 6'd42, 6'd53, 6'd9});
  endtask

  // number to character codes: zero, max, negative, all digit values
  task automatic test_char_directed();
    send_item(OP_CHAR, 1'b0, '0, '0);
    send_item(OP_CHAR, 1'b0, WordMax, WordMax);
    send_item(OP_CHAR, 1'b1, WordMax, '0);
    send_item(OP_CHAR, 1'b1, 30'd160826066, WordMax);
    send_item(OP_CHAR, 1'b0, 30'd999999999, 30'h15555555);
    send_item(OP_CHAR, 1'b0, 30'd1000000000, 30'h2aaaaaaa);
    send_item(OP_CHAR, 1'b1, 30'd9876543, '0);
  endtask

  // random mix of both operations, NUM items mostly built from decimal numbers
  task automatic test_random_stream(input int count);
    op_e             op;
    longint unsigned n;
    for (int i = 0; i < count; i++) begin
      op = op_e'($urandom_range(1));
      if (op == OP_CHAR || $urandom_range(3) == 0) begin
        send_item(op, 1'($urandom), WordW'($urandom), WordW'($urandom));
      end else begin
        case ($urandom_range(2))
          0:       n = WordLimit - 2000 + $urandom_range(4000);
          1:       n = {$urandom, $urandom} % 64'd10000000000;
          default: n = $urandom_range(99999);
        endcase
        send_number(1'($urandom), n, 1'($urandom));
      end
    end
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = {m_axis_tdata[0], m_axis_tdata[30:1], m_axis_tdata[60:31], m_axis_tdata[61]};
      if (pending_results.size() == 0) begin
        $display("unexpected result at %0t: 0x%0h", $realtime, m_axis_tdata);
        err_count++;
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.sign !== want_res.sign) report_mismatch("acc_sign", WordW'(got_res.sign),
                                                            WordW'(want_res.sign));
        if (got_res.acc !== want_res.acc) report_mismatch("acc_word", got_res.acc, want_res.acc);
        if (got_res.ext !== want_res.ext) report_mismatch("ext_word", got_res.ext, want_res.ext);
        if (got_res.ovf !== want_res.ovf) report_mismatch("overflow", WordW'(got_res.ovf),
                                                          WordW'(want_res.ovf));
      end
    end
  end

  // run limit
  initial begin
    #1000000;
    $display("status: fail");
    $finish;
  end

  // main sequence
  initial begin
    err_count      = 0;
    src_idle_pct   = 30;
    sink_stall_pct = 52;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    m_axis_tready  = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_num_directed();
    test_char_directed();
    test_random_stream(320);
    src_idle_pct   = 52;
    sink_stall_pct = 30;
    test_random_stream(320);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    test_random_stream(310);
    s_axis_tvalid <= 1'b0;

    // drain, then watch for stray results
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4 * NumStages) @(posedge clk_i);

    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### decimal_char_numeric_convert_unit.f
sv/dcnc_pkg.sv
sv/dcnc_pipe_ctrl.sv
sv/dcnc_num_path.sv
sv/dcnc_char_path.sv
sv/decimal_char_numeric_convert_unit.sv
tb/testbench.sv
